[rtl/indexed_insert_remove_list_assert.svh]
// assertion macros used by the bound checker file
`ifndef INDEXED_INSERT_REMOVE_LIST_ASSERT_SVH
`define INDEXED_INSERT_REMOVE_LIST_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define IIRL_ASSERT_NOW(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define IIRL_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/iirl_pkg.sv]
// ----------------------------------------------------------------------------
// iirl_pkg
// Shared codes, field widths and cell control type of the indexed list.
// ----------------------------------------------------------------------------
package iirl_pkg;

    localparam int OP_W     = 2;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int BYTES_W  = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int CAP_W    = 5;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SIZE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // broadcast to every cell for one beat
    typedef struct packed {
        logic ins;   // insert: shift up above position, load at position
        logic rem;   // remove: shift down from position on
    } cell_ctl_t;

endpackage

[rtl/indexed_insert_remove_list.sv]
// ----------------------------------------------------------------------------
// indexed_insert_remove_list
// Ordered list of 32-bit entries with insert, remove and read at an index.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one operation per beat (clear, insert, remove, read)
//   with position, entry data and the claimed entry size. The m_ channel
//   returns one beat per operation: status, read data and entry count.
//   cfg_wr_en / cfg_wr_data set the capacity; write it only while idle.
//   The result is registered at the accepting edge. Throughput is one
//   operation per cycle unless a result beat is stalled; every slot is a
//   cell of a shift chain, so an insert or remove moves all later entries.
//   A read selects the addressed cell through an or-tree over DEPTH cells.
//   While a result beat waits on a low m_ready, s_ready is low; with m_ready
//   high a new operation is taken in the same cycle the result leaves.
//   Reset empties the list and sets capacity to 16; stored entries are not
//   cleared and are only read after being written.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list
    import iirl_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int ENTRY_BYTES = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CAP_W-1:0]    cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_op,
    input  logic [POS_W-1:0]    s_position,
    input  logic [DATA_W-1:0]   s_entry_data,
    input  logic [BYTES_W-1:0]  s_claimed_bytes,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [DATA_W-1:0]   m_read_data,
    output logic [COUNT_W-1:0]  m_entry_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW0   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int CW    = (CW0 > CAP_W) ? CW0 : CAP_W;

    logic [CAP_W-1:0]    cap_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [DATA_W-1:0]   rdata_reg;
    logic [DATA_W-1:0]   rdata_next;

    logic                accept;
    logic [CW-1:0]       cnt_w;
    logic [CW-1:0]       pos_w;
    logic [CW-1:0]       cap_w;
    logic [CW-1:0]       cap_eff;
    cell_ctl_t           ctl;
    logic [DATA_W-1:0]   rd_sel;

    logic [DATA_W-1:0]   cell_data [DEPTH];
    logic [DATA_W-1:0]   cell_rd   [DEPTH];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign cnt_w   = CW'(count_reg);
    assign pos_w   = CW'(s_position);
    assign cap_w   = CW'(cap_reg);
    assign cap_eff = (cap_w > CW'(DEPTH)) ? CW'(DEPTH) : cap_w;

    always_comb begin
        rd_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_sel = rd_sel | cell_rd[i];
        end
    end

    always_comb begin
        status_next = ST_OK;
        rdata_next  = '0;
        count_next  = count_reg;
        ctl         = '0;
        case (s_op)
            OP_CLEAR: begin
                count_next = '0;
            end
            OP_INSERT: begin
                if (s_claimed_bytes != BYTES_W'(ENTRY_BYTES)) begin
                    status_next = ST_SIZE;
                end else if (cnt_w >= cap_eff) begin
                    status_next = ST_FULL;
                end else if (pos_w > cnt_w) begin
                    status_next = ST_RANGE;
                end else begin
                    ctl.ins    = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE, OP_READ: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else if (pos_w >= cnt_w) begin
                    status_next = ST_RANGE;
                end else if (s_op == OP_REMOVE) begin
                    ctl.rem    = accept;
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    rdata_next = rd_sel;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_W-1:0] prev_d;
            logic [DATA_W-1:0] next_d;
            if (g == 0) begin : g_first
                assign prev_d = cell_data[g];
            end else begin : g_mid
                assign prev_d = cell_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign next_d = cell_data[g];
            end else begin : g_body
                assign next_d = cell_data[g+1];
            end
            iirl_cell #(
                .IDX (g),
                .PW  (CW)
            ) u_cell (
                .aclk   (aclk),
                .ctl_i  (ctl),
                .pos_i  (pos_w),
                .prev_i (prev_d),
                .next_i (next_d),
                .new_i  (s_entry_data),
                .data_o (cell_data[g]),
                .rd_o   (cell_rd[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (accept) begin
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_read_data   = rdata_reg;
    assign m_entry_count = COUNT_W'(count_reg);

endmodule

[rtl/iirl_cell.sv]
// ----------------------------------------------------------------------------
// iirl_cell
// One list slot: holds an entry and takes its neighbor's on a shift.
// ----------------------------------------------------------------------------
module iirl_cell
    import iirl_pkg::*;
#(
    parameter int IDX = 0,
    parameter int PW  = 5
) (
    input  logic              aclk,
    input  cell_ctl_t         ctl_i,
    input  logic [PW-1:0]     pos_i,
    input  logic [DATA_W-1:0] prev_i,
    input  logic [DATA_W-1:0] next_i,
    input  logic [DATA_W-1:0] new_i,
    output logic [DATA_W-1:0] data_o,
    output logic [DATA_W-1:0] rd_o
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              above;
    logic              at;

    assign above = PW'(IDX) > pos_i;
    assign at    = PW'(IDX) == pos_i;

    always_comb begin
        data_next = data_reg;
        if (ctl_i.ins) begin
            if (above) begin
                data_next = prev_i;
            end else if (at) begin
                data_next = new_i;
            end
        end else if (ctl_i.rem) begin
            if (above || at) begin
                data_next = next_i;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_o = data_reg;
    // gated copy for the read or-tree
    assign rd_o   = at ? data_reg : '0;

endmodule

[rtl/iirl_checker.sv]
// ----------------------------------------------------------------------------
// iirl_checker
// Port-level checks of the indexed list, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_insert_remove_list_assert.svh"

module iirl_checker
    import iirl_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [OP_W-1:0]     s_op,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [DATA_W-1:0]   m_read_data,
    input logic [COUNT_W-1:0]  m_entry_count
);

    // stalled result beat holds
    `IIRL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_status) && $stable(m_read_data) && $stable(m_entry_count),
        "result beat changed while stalled")

    // a clear always returns ok with an empty list
    `IIRL_ASSERT_NEXT(a_clear, aclk, aresetn, s_valid && s_ready && s_op == OP_CLEAR,
        m_valid && m_status == ST_OK && m_entry_count == '0,
        "clear did not report ok with zero entries")

    // read data is zero on every failed result
    `IIRL_ASSERT_NOW(a_rdata_zero, aclk, aresetn, m_valid && m_status != ST_OK,
        m_read_data == '0, "nonzero read data on a failed result")

    // status is one of the defined codes
    `IIRL_ASSERT_NOW(a_status_code, aclk, aresetn, m_valid,
        m_status == ST_OK || m_status == ST_SIZE || m_status == ST_FULL ||
        m_status == ST_RANGE || m_status == ST_EMPTY,
        "undefined status code")

    // an empty result always reports zero entries
    `IIRL_ASSERT_NOW(a_empty_count, aclk, aresetn, m_valid && m_status == ST_EMPTY,
        m_entry_count == '0, "empty status with a nonzero count")

endmodule

bind indexed_insert_remove_list iirl_checker u_iirl_checker (.*);

[tb/sv/indexed_insert_remove_list_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_checker
// Watches both channels and the capacity write port of the indexed list,
// keeps a shadow copy of the list, predicts one result per accepted
// operation and compares every result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_checker
    import iirl_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int ENTRY_BYTES = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CAP_W-1:0]    cfg_wr_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [OP_W-1:0]     s_op,
    input  logic [POS_W-1:0]    s_position,
    input  logic [DATA_W-1:0]   s_entry_data,
    input  logic [BYTES_W-1:0]  s_claimed_bytes,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [STATUS_W-1:0] m_status,
    input  logic [DATA_W-1:0]   m_read_data,
    input  logic [COUNT_W-1:0]  m_entry_count,
    output int                  failures,
    output int                  results_due
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   read_data;
        logic [COUNT_W-1:0]  entry_count;
    } list_result_t;

    logic [DATA_W-1:0]  shadow_entries [DEPTH];
    logic [COUNT_W-1:0] shadow_count;
    logic [CAP_W-1:0]   shadow_cap;
    list_result_t       due_results [$];
    list_result_t       oldest_due;
    int                 fail_count = 0;
    int                 due_count  = 0;

    assign failures    = fail_count;
    assign results_due = due_count;

    task automatic report_mismatch(input string msg);
        $display("%0t ns list check: %s", $time, msg);
        fail_count++;
    endtask

    // applies one operation to the shadow list and returns its result
    function automatic list_result_t apply_list_op(
        input logic [OP_W-1:0]    op,
        input logic [POS_W-1:0]   pos,
        input logic [DATA_W-1:0]  data,
        input logic [BYTES_W-1:0] claimed
    );
        list_result_t res;
        int           eff_cap;
        int           idx;
        res        = '0;
        res.status = ST_OK;
        // capacity above the store size saturates
        eff_cap = (int'(shadow_cap) > DEPTH) ? DEPTH : int'(shadow_cap);
        case (op)
            OP_CLEAR: begin
                shadow_count = '0;
            end
            OP_INSERT: begin
                if (int'(claimed) != ENTRY_BYTES) begin
                    res.status = ST_SIZE;
                end else if (int'(shadow_count) >= eff_cap) begin
                    res.status = ST_FULL;
                end else if (pos > shadow_count) begin
                    res.status = ST_RANGE;
                end else begin
                    for (idx = int'(shadow_count); idx > int'(pos); idx--)
                        shadow_entries[idx] = shadow_entries[idx-1];
                    shadow_entries[pos] = data;
                    shadow_count++;
                end
            end
            default: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos >= shadow_count) begin
                    res.status = ST_RANGE;
                end else if (op == OP_REMOVE) begin
                    for (idx = int'(pos); idx + 1 < int'(shadow_count); idx++)
                        shadow_entries[idx] = shadow_entries[idx+1];
                    shadow_count--;
                end else begin
                    res.read_data = shadow_entries[pos];
                end
            end
        endcase
        res.entry_count = shadow_count;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            shadow_count = '0;
            shadow_cap   = CAP_RESET;
            due_results.delete();
        end else begin
            // a result beat always belongs to an operation from an earlier edge
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result beat with no operation outstanding");
                end else begin
                    oldest_due = due_results.pop_front();
                    if (m_status !== oldest_due.status)
                        report_mismatch($sformatf("status got %0d exp %0d",
                            m_status, oldest_due.status));
                    if (m_read_data !== oldest_due.read_data)
                        report_mismatch($sformatf("read_data got %h exp %h",
                            m_read_data, oldest_due.read_data));
                    if (m_entry_count !== oldest_due.entry_count)
                        report_mismatch($sformatf("entry_count got %0d exp %0d",
                            m_entry_count, oldest_due.entry_count));
                end
            end
            if (cfg_wr_en)
                shadow_cap = cfg_wr_data;
            if (s_valid && s_ready)
                due_results.push_back(apply_list_op(s_op, s_position, s_entry_data,
                                                    s_claimed_bytes));
        end
        due_count = due_results.size();
    end

endmodule

[tb/sv/indexed_insert_remove_list_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_test
// Drives the indexed list with a directed set of edge cases, then random
// operation mixes over several capacity settings and handshake idling
// patterns; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_test;
    import iirl_pkg::*;

    localparam int DEPTH           = 16;
    localparam int ENTRY_BYTES     = 4;
    localparam int NUM_PHASES      = 10;
    localparam int BEATS_PER_PHASE = 135;
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic [BYTES_W-1:0] CLAIM_OK = BYTES_W'(ENTRY_BYTES);
    // last phase gets a random capacity instead
    localparam logic [CAP_W-1:0] PHASE_CAPS [NUM_PHASES] =
        '{5'd16, 5'd3, 5'd0, 5'd16, 5'd31, 5'd1, 5'd17, 5'd16, 5'd7, 5'd16};

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                cfg_wr_en       = 1'b0;
    logic [CAP_W-1:0]    cfg_wr_data     = '0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op            = OP_CLEAR;
    logic [POS_W-1:0]    s_position      = '0;
    logic [DATA_W-1:0]   s_entry_data    = '0;
    logic [BYTES_W-1:0]  s_claimed_bytes = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [DATA_W-1:0]   m_read_data;
    logic [COUNT_W-1:0]  m_entry_count;

    int failures;
    int results_due;
    int cycles        = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    indexed_insert_remove_list #(
        .DEPTH       (DEPTH),
        .ENTRY_BYTES (ENTRY_BYTES)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_position      (s_position),
        .s_entry_data    (s_entry_data),
        .s_claimed_bytes (s_claimed_bytes),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_read_data     (m_read_data),
        .m_entry_count   (m_entry_count)
    );

    indexed_insert_remove_list_checker #(
        .DEPTH       (DEPTH),
        .ENTRY_BYTES (ENTRY_BYTES)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_position      (s_position),
        .s_entry_data    (s_entry_data),
        .s_claimed_bytes (s_claimed_bytes),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_read_data     (m_read_data),
        .m_entry_count   (m_entry_count),
        .failures        (failures),
        .results_due     (results_due)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL indexed_insert_remove_list");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // one beat on the operation channel; valid stays up until accepted
    task automatic send_beat(
        input logic [OP_W-1:0]    op,
        input logic [POS_W-1:0]   pos,
        input logic [DATA_W-1:0]  data,
        input logic [BYTES_W-1:0] claimed
    );
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_position      <= pos;
        s_entry_data    <= data;
        s_claimed_bytes <= claimed;
        do @(posedge aclk); while (!s_ready);
    endtask

    // wait until every outstanding result has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (results_due != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int                 ph;
        int                 k;
        int                 r;
        int                 eff_cap;
        logic [CAP_W-1:0]   cap_now;
        logic [OP_W-1:0]    op;
        logic [POS_W-1:0]   pos;
        logic [BYTES_W-1:0] claimed;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty list, size and range errors, ends and middle, clear
        send_beat(OP_READ,   5'd0,  32'h0,        8'd0);
        send_beat(OP_REMOVE, 5'd0,  32'h0,        8'd0);
        send_beat(OP_INSERT, 5'd0,  32'h12345678, 8'd3);
        send_beat(OP_INSERT, 5'd1,  32'h11111111, CLAIM_OK);
        send_beat(OP_INSERT, 5'd0,  32'hffffffff, CLAIM_OK);
        send_beat(OP_INSERT, 5'd0,  32'h00000000, CLAIM_OK);
        send_beat(OP_INSERT, 5'd2,  32'ha5a5a5a5, CLAIM_OK);
        send_beat(OP_INSERT, 5'd1,  32'h5a5a5a5a, CLAIM_OK);
        send_beat(OP_INSERT, 5'd31, 32'h22222222, CLAIM_OK);
        send_beat(OP_INSERT, 5'd0,  32'h33333333, 8'd255);
        send_beat(OP_INSERT, 5'd0,  32'h44444444, 8'd0);
        send_beat(OP_READ,   5'd0,  32'hffffffff, 8'd255);
        send_beat(OP_READ,   5'd3,  32'h0,        8'd0);
        send_beat(OP_READ,   5'd4,  32'h0,        8'd0);
        send_beat(OP_READ,   5'd31, 32'h0,        8'd0);
        send_beat(OP_REMOVE, 5'd1,  32'hdeadbeef, 8'd7);
        send_beat(OP_REMOVE, 5'd2,  32'h0,        8'd0);
        send_beat(OP_READ,   5'd1,  32'h0,        8'd0);
        send_beat(OP_REMOVE, 5'd31, 32'h0,        8'd0);
        send_beat(OP_CLEAR,  5'd31, 32'hdeadbeef, CLAIM_OK);
        send_beat(OP_READ,   5'd0,  32'h0,        8'd0);
        send_beat(OP_INSERT, 5'd0,  32'hcafef00d, CLAIM_OK);
        send_beat(OP_READ,   5'd0,  32'h0,        8'd0);

        // random: entries are kept across capacity changes on purpose
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            cap_now = (ph == NUM_PHASES - 1) ? CAP_W'($urandom_range(0, 31))
                                             : PHASE_CAPS[ph];
            write_capacity(cap_now);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 60; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 60; end
                default: begin send_idle_pct = 7; stall_pct = 7; end
            endcase
            eff_cap = (int'(cap_now) > DEPTH) ? DEPTH : int'(cap_now);
            for (k = 0; k < BEATS_PER_PHASE; k++) begin
                r = $urandom_range(0, 99);
                if (r < 3)       op = OP_CLEAR;
                else if (r < 48) op = OP_INSERT;
                else if (r < 72) op = OP_REMOVE;
                else             op = OP_READ;
                r = $urandom_range(0, 99);
                if (r < 70)      pos = POS_W'($urandom_range(0, eff_cap));
                else if (r < 88) pos = POS_W'($urandom_range(0, DEPTH));
                else             pos = POS_W'($urandom_range(0, 31));
                claimed = ($urandom_range(0, 99) < 90) ? CLAIM_OK
                                                       : BYTES_W'($urandom_range(0, 255));
                send_beat(op, pos, $urandom, claimed);
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (failures == 0 && results_due == 0) begin
            $display("PASS indexed_insert_remove_list");
        end else begin
            $display("FAIL indexed_insert_remove_list");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/iirl_pkg.sv
rtl/iirl_cell.sv
rtl/indexed_insert_remove_list.sv
rtl/iirl_checker.sv
tb/sv/indexed_insert_remove_list_checker.sv
tb/sv/indexed_insert_remove_list_test.sv
